// ----- design/mpde_pkg.sv -----
package mpde_pkg;

  localparam int POS_W  = 12;
  localparam int VAL_W  = 16;
  localparam int DIST_W = 24;
  localparam int FRAC_W = 8;

  localparam logic [1:0] ACT_TGT   = 2'd0;
  localparam logic [1:0] ACT_SRC   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] PAIR_TS   = 2'd0;
  localparam logic [1:0] PAIR_TT   = 2'd1;
  localparam logic [1:0] PAIR_SS   = 2'd2;
  localparam logic [1:0] PAIR_NONE = 2'd3;

  localparam logic [1:0] ST_MEAN   = 2'd0;
  localparam logic [1:0] ST_CAND   = 2'd1;
  localparam logic [1:0] ST_CENTRE = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [8:0]  size_x;
    logic [8:0]  size_y;
    logic [8:0]  size_z;
    logic [2:0]  channel_count;
    logic [2:0]  patch_radius;
    logic [15:0] max_distance;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [15:0]       voxel_address;
    logic signed [15:0] voxel_value;
    logic [1:0]        pair_select;
    logic [7:0]        centre_x;
    logic [7:0]        centre_y;
    logic [7:0]        centre_z;
    logic signed [9:0] cand_x;
    logic signed [9:0] cand_y;
    logic signed [9:0] cand_z;
  } item_t;

  typedef struct packed {
    logic       write_tgt;
    logic       write_src;
    logic       load_query;
    logic       issue_check;
    logic       walk_issue;
    logic       div_start;
    logic       res_load;
    logic [1:0] res_code;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic walk_last;
    logic cand_bad;
    logic cent_bad;
    logic count_zero;
    logic div_busy;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [8:0] at_least_one(logic [8:0] v);
    return (v == 9'd0) ? 9'd1 : v;
  endfunction

  function automatic logic in_range(logic signed [POS_W-1:0] pos, logic [8:0] size);
    return !pos[POS_W-1] && (pos[POS_W-2:0] < (POS_W-1)'(size));
  endfunction

endpackage

// ----- design/mpde_divider.sv -----
module mpde_divider #(
  parameter int NUM_W = 38,
  parameter int DEN_W = 14
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !start && (cnt == CNT_W'(1));
      if (start) begin
        quo  <= num;
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[NUM_W-2:0], ge};
        rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- design/mpde_datapath.sv -----
module mpde_datapath #(
  parameter int STORE_DEPTH  = 65536,
  parameter int MAX_RADIUS   = 7,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mpde_pkg::cfg_t        cfg,
  input  mpde_pkg::item_t       item,
  input  mpde_pkg::cmd_t        cmd,
  output mpde_pkg::sts_t        sts,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,
  output logic [1:0]            m_tuser
);

  localparam int POS_W   = mpde_pkg::POS_W;
  localparam int VAL_W   = mpde_pkg::VAL_W;
  localparam int R_W     = $clog2(MAX_RADIUS + 1);
  localparam int OFF_W   = R_W + 1;
  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int COUNT_W = $clog2((2*MAX_RADIUS+1)**3 * MAX_CHANNELS + 1);
  localparam int SUM_W   = COUNT_W + VAL_W;
  localparam int NUM_W   = SUM_W + mpde_pkg::FRAC_W;
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int T1_W    = CH_W + 10;
  localparam int T2_W    = T1_W + 10;
  localparam int IDX_W   = T2_W + 10;

  // effective configuration
  logic [8:0]            sx_e, sy_e, sz_e;
  logic                  flat;
  logic [R_W-1:0]        r_e;
  logic signed [OFF_W-1:0] r_s, kr_s;
  logic [CH_W-1:0]       c_last;
  logic [15:0]           below;
  int unsigned           nch;

  always_comb begin
    sx_e = mpde_pkg::at_least_one(cfg.size_x);
    sy_e = mpde_pkg::at_least_one(cfg.size_y);
    sz_e = mpde_pkg::at_least_one(cfg.size_z);
    flat = (sz_e == 9'd1);
    if (32'(cfg.patch_radius) > MAX_RADIUS) r_e = R_W'(MAX_RADIUS);
    else r_e = R_W'(cfg.patch_radius);
    r_s  = $signed(OFF_W'(r_e));
    kr_s = flat ? '0 : r_s;
    nch  = (cfg.channel_count == 3'd0) ? 1 : 32'(cfg.channel_count);
    if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
    c_last = CH_W'(nch - 1);
    below  = (cfg.max_distance == 16'd0) ? 16'd0 : cfg.max_distance - 16'd1;
  end

  // query registers
  logic signed [POS_W-1:0] cx, cy, cz, qx, qy, qz;
  logic                    first_src, second_src;

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      cx <= POS_W'(item.centre_x);
      cy <= POS_W'(item.centre_y);
      cz <= flat ? '0 : POS_W'(item.centre_z);
      qx <= POS_W'(item.cand_x);
      qy <= POS_W'(item.cand_y);
      qz <= flat ? '0 : POS_W'(item.cand_z);
      first_src  <= (item.pair_select == mpde_pkg::PAIR_SS);
      second_src <= (item.pair_select != mpde_pkg::PAIR_TT);
    end
  end

  // patch walk: x fastest, then y, z, channel
  logic signed [OFF_W-1:0] oi, oj, ok;
  logic [CH_W-1:0]         ch;
  logic                    walk_last;

  assign walk_last = (oi == r_s) && (oj == r_s) && (ok == kr_s) && (ch == c_last);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      oi <= -r_s;
      oj <= -r_s;
      ok <= -kr_s;
      ch <= '0;
    end else if (cmd.walk_issue) begin
      if (oi != r_s) begin
        oi <= oi + OFF_W'(1);
      end else begin
        oi <= -r_s;
        if (oj != r_s) begin
          oj <= oj + OFF_W'(1);
        end else begin
          oj <= -r_s;
          if (ok != kr_s) begin
            ok <= ok + OFF_W'(1);
          end else begin
            ok <= -kr_s;
            ch <= ch + CH_W'(1);
          end
        end
      end
    end
  end

  // issue stage: side 0 is the first image, side 1 the second
  logic signed [OFF_W-1:0] si, sj, sk;
  logic [CH_W-1:0]         sc;
  logic                    issue;
  logic signed [POS_W-1:0] px [2];
  logic signed [POS_W-1:0] py [2];
  logic signed [POS_W-1:0] pz [2];
  logic                    inr [2];

  assign issue = cmd.issue_check || cmd.walk_issue;
  assign si = cmd.issue_check ? '0 : oi;
  assign sj = cmd.issue_check ? '0 : oj;
  assign sk = cmd.issue_check ? '0 : ok;
  assign sc = cmd.issue_check ? '0 : ch;

  assign px[0] = cx + POS_W'(si);
  assign py[0] = cy + POS_W'(sj);
  assign pz[0] = cz + POS_W'(sk);
  assign px[1] = qx + POS_W'(si);
  assign py[1] = qy + POS_W'(sj);
  assign pz[1] = qz + POS_W'(sk);

  logic [7:0]       x1 [2];
  logic [7:0]       y1 [2];
  logic [T1_W-1:0]  t1 [2];
  logic             in1 [2];
  logic [7:0]       x2 [2];
  logic [T2_W-1:0]  t2 [2];
  logic             in2 [2];
  logic [IDX_W-1:0] idx3 [2];
  logic             in3 [2];
  logic             oor4 [2];
  logic             in4 [2];
  logic [VAL_W-1:0] tgt_rd [2];
  logic [VAL_W-1:0] src_rd [2];

  logic [VAL_W-1:0] tgt_mem [STORE_DEPTH];
  logic [VAL_W-1:0] src_mem [STORE_DEPTH];
  logic [31:0]      wr_wide;
  logic             wr_ok;

  assign wr_wide = 32'(item.voxel_address);
  assign wr_ok   = wr_wide < 32'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.write_tgt && wr_ok) tgt_mem[wr_wide[ADDR_W-1:0]] <= item.voxel_value;
    if (cmd.write_src && wr_ok) src_mem[wr_wide[ADDR_W-1:0]] <= item.voxel_value;
  end

  for (genvar g = 0; g < 2; g++) begin : g_side
    assign inr[g] = mpde_pkg::in_range(px[g], sx_e) && mpde_pkg::in_range(py[g], sy_e) &&
                    mpde_pkg::in_range(pz[g], sz_e);

    always_ff @(posedge clk) begin
      x1[g]   <= px[g][7:0];
      y1[g]   <= py[g][7:0];
      t1[g]   <= T1_W'(pz[g][7:0]) + T1_W'(sz_e) * T1_W'(sc);
      in1[g]  <= inr[g];
      x2[g]   <= x1[g];
      t2[g]   <= T2_W'(y1[g]) + T2_W'(sy_e) * T2_W'(t1[g]);
      in2[g]  <= in1[g];
      idx3[g] <= IDX_W'(x2[g]) + IDX_W'(sx_e) * IDX_W'(t2[g]);
      in3[g]  <= in2[g];
      oor4[g] <= idx3[g] >= IDX_W'(STORE_DEPTH);
      in4[g]  <= in3[g];
      tgt_rd[g] <= tgt_mem[idx3[g][ADDR_W-1:0]];
      src_rd[g] <= src_mem[idx3[g][ADDR_W-1:0]];
    end
  end

  logic v1, v2, v3, v4;
  logic chk1, chk2, chk3, chk4;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4} <= '0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
    chk1 <= cmd.issue_check;
    chk2 <= chk1;
    chk3 <= chk2;
    chk4 <= chk3;
  end

  // accumulate
  logic [VAL_W-1:0]   va, vb;
  logic signed [VAL_W:0] d;
  logic [VAL_W:0]     absd;
  logic [SUM_W-1:0]   sum;
  logic [COUNT_W-1:0] count;
  logic               cand_bad, cent_bad;

  always_comb begin
    va   = oor4[0] ? '0 : (first_src ? src_rd[0] : tgt_rd[0]);
    vb   = oor4[1] ? '0 : (second_src ? src_rd[1] : tgt_rd[1]);
    d    = $signed({va[VAL_W-1], va}) - $signed({vb[VAL_W-1], vb});
    absd = d[VAL_W] ? (~d + (VAL_W+1)'(1)) : d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_bad <= 1'b0;
      cent_bad <= 1'b0;
    end else if (cmd.load_query) begin
      sum      <= '0;
      count    <= '0;
      cand_bad <= 1'b0;
      cent_bad <= 1'b0;
    end else if (v4) begin
      if (chk4) begin
        cand_bad <= !in4[1] || vb[VAL_W-1];
        cent_bad <= !in4[0] || va[VAL_W-1];
      end else if (!(in4[0] && in4[1])) begin
        sum   <= sum + SUM_W'(cfg.max_distance);
        count <= count + COUNT_W'(1);
      end else if (!va[VAL_W-1]) begin
        sum   <= sum + SUM_W'(absd);
        count <= count + COUNT_W'(1);
      end
    end
  end

  logic [NUM_W-1:0] num, quo;
  logic             div_busy, div_done;

  assign num = {sum, 8'b0} + NUM_W'(count >> 1);

  mpde_divider #(
    .NUM_W (NUM_W),
    .DEN_W (COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .num      (num),
    .den      (count),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.res_load) begin
      m_tuser <= cmd.res_code;
      case (cmd.res_code)
        mpde_pkg::ST_MEAN: m_tdata <= quo[mpde_pkg::DIST_W-1:0];
        mpde_pkg::ST_CAND: m_tdata <= {cfg.max_distance, 8'b0};
        default:           m_tdata <= {below, 8'b0};
      endcase
    end
  end

  assign sts.pipe_empty = !(v1 || v2 || v3 || v4);
  assign sts.walk_last  = walk_last;
  assign sts.cand_bad   = cand_bad;
  assign sts.cent_bad   = cent_bad;
  assign sts.count_zero = (count == '0);
  assign sts.div_busy   = div_busy;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !m_tvalid || m_tready;

endmodule

// ----- design/mpde_ctrl.sv -----
module mpde_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [1:0]     action,
  input  logic [1:0]     pair_select,
  input  mpde_pkg::sts_t sts,
  output mpde_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK_ISSUE,
    S_CHK_WAIT,
    S_WALK,
    S_DRAIN,
    S_DIV,
    S_RESULT
  } state_t;

  state_t     state, state_next;
  logic [1:0] code, code_next;
  logic       accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    code_next  = code;
    cmd.res_code = code;
    unique case (state)
      S_IDLE: begin
        cmd.write_tgt  = accept && (action == mpde_pkg::ACT_TGT);
        cmd.write_src  = accept && (action == mpde_pkg::ACT_SRC);
        cmd.load_query = accept && (action == mpde_pkg::ACT_QUERY) &&
                         (pair_select != mpde_pkg::PAIR_NONE);
        if (cmd.load_query) state_next = S_CHK_ISSUE;
      end
      S_CHK_ISSUE: begin
        cmd.issue_check = 1'b1;
        state_next      = S_CHK_WAIT;
      end
      S_CHK_WAIT: begin
        if (sts.pipe_empty) begin
          if (sts.cand_bad) begin
            code_next  = mpde_pkg::ST_CAND;
            state_next = S_RESULT;
          end else if (sts.cent_bad) begin
            code_next  = mpde_pkg::ST_CENTRE;
            state_next = S_RESULT;
          end else begin
            state_next = S_WALK;
          end
        end
      end
      S_WALK: begin
        cmd.walk_issue = 1'b1;
        if (sts.walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.pipe_empty) begin
          if (sts.count_zero) begin
            code_next  = mpde_pkg::ST_EMPTY;
            state_next = S_RESULT;
          end else begin
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          code_next  = mpde_pkg::ST_MEAN;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= mpde_pkg::ST_MEAN;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> sts.pipe_empty && !sts.div_busy)
    else $error("input taken while datapath busy");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");

  a_walk_stops: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_issue && sts.walk_last |=> !cmd.walk_issue)
    else $error("walk ran past last point");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> !cmd.res_load)
    else $error("two results loaded for one query");

endmodule

// ----- design/masked_patch_distance_engine.sv -----
// Masked patch distance engine.
// Input channel (s_*): one transfer per item. s_tuser[1:0] is the action:
// write a target voxel, write a source voxel, or run a query. Writes land in
// the chosen store at the transfer and give no result. A query whose pair_select
// is not PAIR_NONE gives one result transfer on m_*: distance in m_tdata (8
// fractional bits), status in m_tuser.
// Query steps: a centre/candidate check, a walk over the N patch voxels,
// N = channels * (2r+1)^2 * (2r+1 or 1 in 2D), a drain, a restoring division
// of NUM_W quotient bits (NUM_W = 38 at the default parameters; skipped when
// no voxel was counted) and the load of the result.
// A query stopped by the check skips the walk and the division.
// The patch walk is set by one voxel pair read per cycle from the stores; the
// division by the divider producing one quotient bit per cycle.
// One query is in flight at a time; s_tready drops for its duration.
// A finished result waits in the output register while m_tready is low; the
// next item is taken meanwhile and a second result holds until it drains.
// Reset (rst, synchronous) loads the register defaults and clears control;
// store contents are undefined until written.
// Config: APB, registers at 4*i; write only while the block is idle.
module masked_patch_distance_engine #(
  parameter int STORE_DEPTH  = 65536,
  parameter int MAX_RADIUS   = 7,
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // voxel_address, voxel_value, centre_x, centre_y, centre_z, cand_x, cand_y, cand_z
  input  logic [87:0] s_tdata,
  // action, pair_select
  input  logic [3:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // distance_fixed
  output logic [23:0] m_tdata,
  // status
  output logic [1:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [2:0] REG_SIZE_X   = 3'd0;
  localparam logic [2:0] REG_SIZE_Y   = 3'd1;
  localparam logic [2:0] REG_SIZE_Z   = 3'd2;
  localparam logic [2:0] REG_CHANNELS = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;
  localparam logic [2:0] REG_MAX_DIST = 3'd5;

  mpde_pkg::cfg_t  cfg;
  mpde_pkg::item_t item;
  mpde_pkg::cmd_t  cmd;
  mpde_pkg::sts_t  sts;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x        <= 9'd64;
      cfg.size_y        <= 9'd64;
      cfg.size_z        <= 9'd16;
      cfg.channel_count <= 3'd1;
      cfg.patch_radius  <= 3'd2;
      cfg.max_distance  <= 16'hFFFF;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_SIZE_X:   cfg.size_x        <= pwdata[8:0];
        REG_SIZE_Y:   cfg.size_y        <= pwdata[8:0];
        REG_SIZE_Z:   cfg.size_z        <= pwdata[8:0];
        REG_CHANNELS: cfg.channel_count <= pwdata[2:0];
        REG_RADIUS:   cfg.patch_radius  <= pwdata[2:0];
        REG_MAX_DIST: cfg.max_distance  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_SIZE_X:   prdata = 32'(cfg.size_x);
      REG_SIZE_Y:   prdata = 32'(cfg.size_y);
      REG_SIZE_Z:   prdata = 32'(cfg.size_z);
      REG_CHANNELS: prdata = 32'(cfg.channel_count);
      REG_RADIUS:   prdata = 32'(cfg.patch_radius);
      REG_MAX_DIST: prdata = 32'(cfg.max_distance);
      default:      prdata = '0;
    endcase
  end

  assign item.action        = s_tuser[1:0];
  assign item.pair_select   = s_tuser[3:2];
  assign item.voxel_address = s_tdata[15:0];
  assign item.voxel_value   = s_tdata[31:16];
  assign item.centre_x      = s_tdata[39:32];
  assign item.centre_y      = s_tdata[47:40];
  assign item.centre_z      = s_tdata[55:48];
  assign item.cand_x        = s_tdata[65:56];
  assign item.cand_y        = s_tdata[75:66];
  assign item.cand_z        = s_tdata[85:76];

  mpde_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .action      (item.action),
    .pair_select (item.pair_select),
    .sts         (sts),
    .cmd         (cmd)
  );

  mpde_datapath #(
    .STORE_DEPTH  (STORE_DEPTH),
    .MAX_RADIUS   (MAX_RADIUS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (item),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
